>>> design/eab_pkg.sv
package eab_pkg;

  localparam int unsigned FIELD_W = 16;
  localparam int unsigned PHASE_W = 32;
  localparam int unsigned CW = 34;
  localparam longint unsigned GainQ30 = 64'd652032874;

  typedef logic signed [FIELD_W-1:0] field_t;

  typedef struct packed {
    field_t pitch_angle;
    field_t yaw_angle;
    field_t roll_angle;
  } angles_t;

  typedef struct packed {
    field_t forward_x;
    field_t forward_y;
    field_t forward_z;
    field_t up_x;
    field_t up_y;
    field_t up_z;
    field_t side_x;
    field_t side_y;
    field_t side_z;
  } basis_t;

  function automatic logic [PHASE_W-1:0] atan_turn(input int unsigned i);
    logic [PHASE_W-1:0] r;
    case (i)
      0: r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
      3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
      6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
      9: r = 32'h00145F2F;  10: r = 32'h000A2F98; 11: r = 32'h000517CC;
      12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
      15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
      18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
      21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
      24: r = 32'h00000029; 25: r = 32'h00000014; 26: r = 32'h0000000A;
      27: r = 32'h00000005; 28: r = 32'h00000003; 29: r = 32'h00000001;
      30: r = 32'h00000001;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> design/eab_if.sv
interface eab_in_if;
  import eab_pkg::*;
  logic    valid;
  logic    ready;
  angles_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface eab_out_if;
  import eab_pkg::*;
  logic   valid;
  logic   ready;
  basis_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/euler_angles_to_basis_vectors.sv
// Streaming Euler-angle to basis-vector converter. One item per cycle is accepted while the
// output is not stalled. The stages (TRIG_STAGES capped at 32) are: one phase-fold stage, the CORDIC stages
// (three angles run in parallel lanes), a trig rounding stage, two product stages and the
// sum/saturate stage that drives the output. The whole pipeline advances together and holds
// when the output is stalled.
module euler_angles_to_basis_vectors #(
  parameter int unsigned ANGLE_BITS  = 16,
  parameter int unsigned FRAC_BITS   = 14,
  parameter int unsigned TRIG_STAGES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  eab_in_if.sink    in_i,
  eab_out_if.source out_o
);
  import eab_pkg::*;

  localparam int unsigned NS = (TRIG_STAGES > 32) ? 32 : TRIG_STAGES;
  localparam int unsigned QW = FRAC_BITS + 2;
  localparam int unsigned PW = 2 * QW;
  localparam int unsigned TSH = 30 - FRAC_BITS;
  localparam int unsigned NV = NS + 5;

  typedef logic signed [CW-1:0] cv_t;
  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [PW-1:0] p_t;

  logic adv;
  logic [NV-1:0] v_q;

  assign adv = out_o.ready || !out_o.valid;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NV-2:0], in_i.valid};
    end
  end
  assign out_o.valid = v_q[NV-1];

  function automatic q_t sat(input logic signed [PW:0] v);
    logic signed [PW:0] one;
    one = (PW+1)'(1) <<< FRAC_BITS;
    if (v > one) return q_t'(one);
    if (v < -one) return q_t'(-one);
    return q_t'(v);
  endfunction

  function automatic q_t mq(input q_t a, input q_t b);
    p_t pr;
    pr = PW'(a) * PW'(b) + (PW'(1) <<< (FRAC_BITS - 1));
    return q_t'(pr >>> FRAC_BITS);
  endfunction

  // fold stage
  logic [2:0][1:0]      quad_q [NS+1];
  cv_t  [2:0]           x_q [NS+1];
  cv_t  [2:0]           y_q [NS+1];
  cv_t  [2:0]           z_q [NS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        logic [PHASE_W-1:0] ph;
        ph = {in_i.data[16*(2-a) +: 16], 16'h0};
        ph = ph & ~((PHASE_W'(1) << (PHASE_W - ANGLE_BITS)) - PHASE_W'(1));
        quad_q[0][a] <= ph[31:30];
        x_q[0][a] <= cv_t'(GainQ30);
        y_q[0][a] <= '0;
        z_q[0][a] <= cv_t'({2'b00, ph[29:0]});
      end
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_cordic
    always_ff @(posedge clk_i) begin
      if (adv) begin
        quad_q[s+1] <= quad_q[s];
        for (int a = 0; a < 3; a++) begin
          if (!z_q[s][a][CW-1]) begin
            x_q[s+1][a] <= x_q[s][a] - (y_q[s][a] >>> s);
            y_q[s+1][a] <= y_q[s][a] + (x_q[s][a] >>> s);
            z_q[s+1][a] <= z_q[s][a] - cv_t'(atan_turn(s));
          end else begin
            x_q[s+1][a] <= x_q[s][a] + (y_q[s][a] >>> s);
            y_q[s+1][a] <= y_q[s][a] - (x_q[s][a] >>> s);
            z_q[s+1][a] <= z_q[s][a] + cv_t'(atan_turn(s));
          end
        end
      end
    end
  end

  // trig round and quadrant
  q_t [2:0] s_q, c_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        cv_t rx, ry;
        q_t c, sn;
        rx = (x_q[NS][a] + (cv_t'(1) <<< (TSH - 1))) >>> TSH;
        ry = (y_q[NS][a] + (cv_t'(1) <<< (TSH - 1))) >>> TSH;
        c = sat((PW+1)'(rx));
        sn = sat((PW+1)'(ry));
        case (quad_q[NS][a])
          2'd0: begin c_q[a] <= c; s_q[a] <= sn; end
          2'd1: begin c_q[a] <= -sn; s_q[a] <= c; end
          2'd2: begin c_q[a] <= -c; s_q[a] <= -sn; end
          default: begin c_q[a] <= sn; s_q[a] <= -c; end
        endcase
      end
    end
  end

  // a=0 pitch(x), 1 yaw(y), 2 roll(z)
  q_t sx1_q, cx1_q, sy1_q, cy1_q, sz1_q, cz1_q;
  q_t czsx_q, sxcy_q, sxsy_q, sxsz_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx1_q <= s_q[0]; cx1_q <= c_q[0];
      sy1_q <= s_q[1]; cy1_q <= c_q[1];
      sz1_q <= s_q[2]; cz1_q <= c_q[2];
      czsx_q <= mq(c_q[2], s_q[0]);
      sxcy_q <= mq(s_q[0], c_q[1]);
      sxsy_q <= mq(s_q[0], s_q[1]);
      sxsz_q <= mq(s_q[0], s_q[2]);
    end
  end

  q_t [8:0] m_q;
  q_t [2:0] t_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_q[0] <= mq(cx1_q, sy1_q);
      m_q[1] <= sx1_q;
      m_q[2] <= mq(cx1_q, cy1_q);
      m_q[3] <= mq(czsx_q, sy1_q);
      m_q[4] <= mq(sz1_q, cy1_q);
      m_q[5] <= mq(cx1_q, cz1_q);
      m_q[6] <= mq(sy1_q, sz1_q);
      m_q[7] <= mq(sxcy_q, cz1_q);
      m_q[8] <= mq(sxsy_q, sz1_q);
      t_q[0] <= mq(cy1_q, cz1_q);
      t_q[1] <= mq(cx1_q, sz1_q);
      t_q[2] <= mq(sxsz_q, cy1_q);
    end
  end
  q_t czsy_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      czsy_q <= mq(cz1_q, sy1_q);
    end
  end

  q_t [8:0] r_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_q[0] <= sat(-(PW+1)'(m_q[0]));
      r_q[1] <= sat((PW+1)'(m_q[1]));
      r_q[2] <= sat(-(PW+1)'(m_q[2]));
      r_q[3] <= sat((PW+1)'(m_q[3]) - (PW+1)'(m_q[4]));
      r_q[4] <= sat((PW+1)'(m_q[5]));
      r_q[5] <= sat((PW+1)'(m_q[6]) + (PW+1)'(m_q[7]));
      r_q[6] <= sat((PW+1)'(m_q[8]) + (PW+1)'(t_q[0]));
      r_q[7] <= sat((PW+1)'(t_q[1]));
      r_q[8] <= sat((PW+1)'(t_q[2]) - (PW+1)'(czsy_q));
    end
  end

  assign out_o.data.forward_x = field_t'(r_q[0]);
  assign out_o.data.forward_y = field_t'(r_q[1]);
  assign out_o.data.forward_z = field_t'(r_q[2]);
  assign out_o.data.up_x      = field_t'(r_q[3]);
  assign out_o.data.up_y      = field_t'(r_q[4]);
  assign out_o.data.up_z      = field_t'(r_q[5]);
  assign out_o.data.side_x    = field_t'(r_q[6]);
  assign out_o.data.side_y    = field_t'(r_q[7]);
  assign out_o.data.side_z    = field_t'(r_q[8]);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(r_q))
    else $error("stalled result changed");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("pipeline blocked while output empty");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready && !in_i.valid && v_q[NV-2:0] == '0 |=> !out_o.valid)
    else $error("result invented");
endmodule
